[src/lhc_pkg.sv]
// Shared types, constants and threshold tables of the latency histogram counters.
package lhc_pkg;

	localparam int NUM_CATEGORIES_DEF     = 8;
	localparam int NUM_EVENT_COUNTERS_DEF = 18;
	localparam int COUNTER_WIDTH_DEF      = 64;

	localparam int NUM_SLOTS  = 9;
	localparam int NUM_FINITE = 6;
	localparam int SLOT_INF   = 6;
	localparam int SLOT_SUM   = 7;
	localparam int SLOT_COUNT = 8;

	localparam logic [2:0] OP_RECORD     = 3'd0;
	localparam logic [2:0] OP_EVENT      = 3'd1;
	localparam logic [2:0] OP_READ_HIST  = 3'd2;
	localparam logic [2:0] OP_READ_EVENT = 3'd3;
	localparam logic [2:0] OP_CLEAR      = 3'd4;

	localparam logic [1:0] CLS_FAST = 2'd0;
	localparam logic [1:0] CLS_MID  = 2'd1;
	localparam logic [1:0] CLS_SLOW = 2'd2;

	typedef struct packed {
		logic        rec_en;
		logic        clr;
		logic [4:0]  index;
		logic [31:0] lat;
		logic [3:0]  slot;
	} hist_cmd_t;

	typedef struct packed {
		logic       inc_en;
		logic       clr;
		logic [4:0] index;
	} ev_cmd_t;

	typedef struct packed {
		logic [63:0] value;
		logic        exists;
	} rd_t;

	function automatic logic [1:0] cls_of(logic [4:0] cat);
		logic [1:0] cls;
		if (cat <= 5'd1) begin
			cls = CLS_FAST;
		end else if (cat == 5'd2) begin
			cls = CLS_MID;
		end else begin
			cls = CLS_SLOW;
		end
		return cls;
	endfunction

	function automatic logic [2:0] thr_cnt(logic [1:0] cls);
		return (cls == CLS_SLOW) ? 3'd5 : 3'd6;
	endfunction

	function automatic logic [31:0] thr_ms(logic [1:0] cls, logic [2:0] i);
		logic [31:0] t;
		t = 32'd0;
		case (cls)
			CLS_FAST: begin
				case (i)
					3'd0: t = 32'd1;
					3'd1: t = 32'd10;
					3'd2: t = 32'd100;
					3'd3: t = 32'd500;
					3'd4: t = 32'd1000;
					3'd5: t = 32'd2500;
					default: t = 32'd0;
				endcase
			end
			CLS_MID: begin
				case (i)
					3'd0: t = 32'd10;
					3'd1: t = 32'd100;
					3'd2: t = 32'd500;
					3'd3: t = 32'd1000;
					3'd4: t = 32'd2000;
					3'd5: t = 32'd10000;
					default: t = 32'd0;
				endcase
			end
			default: begin
				case (i)
					3'd0: t = 32'd100;
					3'd1: t = 32'd1000;
					3'd2: t = 32'd10000;
					3'd3: t = 32'd30000;
					3'd4: t = 32'd75000;
					default: t = 32'd0;
				endcase
			end
		endcase
		return t;
	endfunction

endpackage

[src/lhc_if.sv]
// Valid/ready channel interfaces for the command and response transfers.
interface lhc_cmd_if;
	logic        valid;
	logic        ready;
	logic [2:0]  operation;
	logic [4:0]  target_index;
	logic [31:0] latency_ms;
	logic [3:0]  slot;

	modport source (output valid, operation, target_index, latency_ms, slot, input ready);
	modport sink (input valid, operation, target_index, latency_ms, slot, output ready);
endinterface

interface lhc_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] read_value;
	logic        slot_exists;

	modport source (output valid, read_value, slot_exists, input ready);
	modport sink (input valid, read_value, slot_exists, output ready);
endinterface

[src/latency_histogram_counters_top.sv]
// Top level of the latency histogram counters: input register, counter banks, result register.
// Each command is registered on transfer. Records, event counts and clears execute in the
// following cycle: records and event counts in a single read-modify-write of one category
// row or one counter, clears by zeroing all rows and counters; one command is taken every
// cycle while no read waits on a full result register. A read returns its response from a
// result register; while that response waits on a stalled response channel, further commands
// that give no response keep flowing, and the next read holds in the input register.
module latency_histogram_counters_top #(
	parameter int NUM_CATEGORIES     = lhc_pkg::NUM_CATEGORIES_DEF,
	parameter int NUM_EVENT_COUNTERS = lhc_pkg::NUM_EVENT_COUNTERS_DEF,
	parameter int COUNTER_WIDTH      = lhc_pkg::COUNTER_WIDTH_DEF
) (
	input logic       clk,
	input logic       arst_n,
	lhc_cmd_if.sink   cmd,
	lhc_rsp_if.source rsp
);
	import lhc_pkg::*;

	logic        valid_s1;
	logic [2:0]  op_s1;
	logic [4:0]  idx_s1;
	logic [31:0] lat_s1;
	logic [3:0]  slot_s1;

	logic        out_valid_q;
	logic [63:0] value_q;
	logic        exists_q;

	logic        is_read;
	logic        out_free;
	logic        fire;
	hist_cmd_t   hcmd;
	ev_cmd_t     ecmd;
	rd_t         hist_rd;
	rd_t         ev_rd;

	assign is_read  = (op_s1 == OP_READ_HIST) || (op_s1 == OP_READ_EVENT);
	assign out_free = !out_valid_q || rsp.ready;
	assign fire     = valid_s1 && (!is_read || out_free);

	assign cmd.ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			op_s1   <= cmd.operation;
			idx_s1  <= cmd.target_index;
			lat_s1  <= cmd.latency_ms;
			slot_s1 <= cmd.slot;
		end
	end

	always_comb begin
		hcmd.rec_en = fire && (op_s1 == OP_RECORD);
		hcmd.clr    = fire && (op_s1 == OP_CLEAR);
		hcmd.index  = idx_s1;
		hcmd.lat    = lat_s1;
		hcmd.slot   = slot_s1;
		ecmd.inc_en = fire && (op_s1 == OP_EVENT);
		ecmd.clr    = fire && (op_s1 == OP_CLEAR);
		ecmd.index  = idx_s1;
	end

	lhc_hist_bank #(
		.NUM_CATEGORIES(NUM_CATEGORIES),
		.COUNTER_WIDTH (COUNTER_WIDTH)
	) u_hist (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (hcmd),
		.rd    (hist_rd)
	);

	lhc_event_bank #(
		.NUM_EVENT_COUNTERS(NUM_EVENT_COUNTERS),
		.COUNTER_WIDTH     (COUNTER_WIDTH)
	) u_event (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (ecmd),
		.rd    (ev_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && is_read) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && is_read) begin
			if (op_s1 == OP_READ_HIST) begin
				value_q  <= hist_rd.value;
				exists_q <= hist_rd.exists;
			end else begin
				value_q  <= ev_rd.value;
				exists_q <= ev_rd.exists;
			end
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.read_value  = value_q;
	assign rsp.slot_exists = exists_q;

	a_read_gives_response: assert property (@(posedge clk) disable iff (!arst_n)
		fire && is_read |=> rsp.valid)
		else $error("Executed read did not load the result register.");

	a_empty_stage_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> cmd.ready)
		else $error("Input register is empty but commands are refused.");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |-> !(fire && is_read))
		else $error("Read executed while a response is still pending.");

	a_silent_ops: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp.valid && !(fire && is_read) |=> !rsp.valid)
		else $error("Response appeared without an executed read.");

endmodule

[src/lhc_hist_bank.sv]
// Per-category histogram rows with registered bucket update and combinational slot read.
module lhc_hist_bank #(
	parameter int NUM_CATEGORIES = 8,
	parameter int COUNTER_WIDTH  = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  lhc_pkg::hist_cmd_t cmd,
	output lhc_pkg::rd_t      rd
);
	import lhc_pkg::*;

	localparam int CAT_W = (NUM_CATEGORIES > 1) ? $clog2(NUM_CATEGORIES) : 1;

	logic [NUM_SLOTS-1:0][COUNTER_WIDTH-1:0] row_q [NUM_CATEGORIES];
	logic [COUNTER_WIDTH-1:0] inc [NUM_SLOTS];
	logic [CAT_W-1:0]         cat_sel;
	logic                     cat_ok;
	logic [1:0]               cls;
	logic                     present;

	assign cat_sel = CAT_W'(cmd.index);
	assign cat_ok  = 32'(cmd.index) < NUM_CATEGORIES;
	assign cls     = cls_of(cmd.index);

	always_comb begin
		for (int i = 0; i < NUM_FINITE; i++) begin
			inc[i] = COUNTER_WIDTH'((3'(i) < thr_cnt(cls)) && (cmd.lat <= thr_ms(cls, 3'(i))));
		end
		inc[SLOT_INF]   = COUNTER_WIDTH'(1'b1);
		inc[SLOT_SUM]   = COUNTER_WIDTH'(cmd.lat);
		inc[SLOT_COUNT] = COUNTER_WIDTH'(1'b1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CATEGORIES; c++) begin
				row_q[c] <= '0;
			end
		end else if (cmd.clr) begin
			for (int c = 0; c < NUM_CATEGORIES; c++) begin
				row_q[c] <= '0;
			end
		end else if (cmd.rec_en && cat_ok) begin
			for (int s = 0; s < NUM_SLOTS; s++) begin
				row_q[cat_sel][s] <= row_q[cat_sel][s] + inc[s];
			end
		end
	end

	// Slot 5 does not exist in categories whose class has only five finite buckets.
	assign present = cat_ok && (cmd.slot < 4'(NUM_SLOTS))
		&& !((cmd.slot < 4'(NUM_FINITE)) && (cmd.slot[2:0] >= thr_cnt(cls)));

	always_comb begin
		rd.exists = present;
		rd.value  = '0;
		if (present) begin
			rd.value = 64'(row_q[cat_sel][cmd.slot]);
		end
	end

endmodule

[src/lhc_event_bank.sv]
// Plain event counters with increment, read and clear.
module lhc_event_bank #(
	parameter int NUM_EVENT_COUNTERS = 18,
	parameter int COUNTER_WIDTH      = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  lhc_pkg::ev_cmd_t cmd,
	output lhc_pkg::rd_t    rd
);
	import lhc_pkg::*;

	localparam int EV_W = (NUM_EVENT_COUNTERS > 1) ? $clog2(NUM_EVENT_COUNTERS) : 1;

	logic [COUNTER_WIDTH-1:0] cnt_q [NUM_EVENT_COUNTERS];
	logic [EV_W-1:0]          ev_sel;
	logic                     ev_ok;

	assign ev_sel = EV_W'(cmd.index);
	assign ev_ok  = 32'(cmd.index) < NUM_EVENT_COUNTERS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int e = 0; e < NUM_EVENT_COUNTERS; e++) begin
				cnt_q[e] <= '0;
			end
		end else if (cmd.clr) begin
			for (int e = 0; e < NUM_EVENT_COUNTERS; e++) begin
				cnt_q[e] <= '0;
			end
		end else if (cmd.inc_en && ev_ok) begin
			cnt_q[ev_sel] <= cnt_q[ev_sel] + COUNTER_WIDTH'(1'b1);
		end
	end

	always_comb begin
		rd.exists = ev_ok;
		rd.value  = '0;
		if (ev_ok) begin
			rd.value = 64'(cnt_q[ev_sel]);
		end
	end

endmodule

[tb/latency_histogram_counters_top_tb.sv]
// Testbench for the latency histogram counters with a scoreboard-checked command stream.
`timescale 1ns / 100ps

module latency_histogram_counters_top_tb;
	import lhc_pkg::*;

	localparam logic [2:0] OP_SPARE_LO = 3'd5;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;
	localparam int QUIET_LIMIT = 3000;
	localparam int RANDOM_PER_PHASE = 238;

	class hist_scoreboard;
		bit [63:0] hist_bins [NUM_CATEGORIES_DEF][NUM_SLOTS];
		bit [63:0] event_counts [NUM_EVENT_COUNTERS_DEF];
		rd_t pending_reads [$];
		int errors;
		int n_records;
		int n_events;
		int n_clears;
		int n_ignored;
		int n_checked;

		function int finite_buckets(int cat);
			return (cat >= 3) ? 5 : 6;
		endfunction

		function bit [31:0] bound_ms(int cat, int i);
			bit [31:0] ms;
			ms = 0;
			if (cat <= 1) begin
				case (i)
					0: ms = 1;
					1: ms = 10;
					2: ms = 100;
					3: ms = 500;
					4: ms = 1000;
					default: ms = 2500;
				endcase
			end else if (cat == 2) begin
				case (i)
					0: ms = 10;
					1: ms = 100;
					2: ms = 500;
					3: ms = 1000;
					4: ms = 2000;
					default: ms = 10000;
				endcase
			end else begin
				case (i)
					0: ms = 100;
					1: ms = 1000;
					2: ms = 10000;
					3: ms = 30000;
					default: ms = 75000;
				endcase
			end
			return ms;
		endfunction

		function void wipe();
			foreach (hist_bins[c, s]) hist_bins[c][s] = 0;
			foreach (event_counts[e]) event_counts[e] = 0;
		endfunction

		function void enqueue_read(rd_t rd);
			pending_reads = {pending_reads, rd};
		endfunction

		function void note_command(logic [2:0] op, logic [4:0] idx, logic [31:0] lat,
				logic [3:0] slot);
			rd_t rd;
			rd.value = '0;
			rd.exists = 1'b0;
			case (op)
				OP_RECORD: begin
					if (idx < NUM_CATEGORIES_DEF) begin
						hist_bins[idx][SLOT_COUNT] += 1;
						hist_bins[idx][SLOT_SUM] += lat;
						for (int i = 0; i < finite_buckets(idx); i++) begin
							if (lat <= bound_ms(idx, i)) begin
								hist_bins[idx][i] += 1;
							end
						end
						hist_bins[idx][SLOT_INF] += 1;
						n_records++;
					end else begin
						n_ignored++;
					end
				end
				OP_EVENT: begin
					if (idx < NUM_EVENT_COUNTERS_DEF) begin
						event_counts[idx] += 1;
						n_events++;
					end else begin
						n_ignored++;
					end
				end
				OP_READ_HIST: begin
					if (idx < NUM_CATEGORIES_DEF && slot < NUM_SLOTS &&
							!(slot < NUM_FINITE && slot >= finite_buckets(idx))) begin
						rd.exists = 1'b1;
						rd.value = hist_bins[idx][slot];
					end
					enqueue_read(rd);
				end
				OP_READ_EVENT: begin
					if (idx < NUM_EVENT_COUNTERS_DEF) begin
						rd.exists = 1'b1;
						rd.value = event_counts[idx];
					end
					enqueue_read(rd);
				end
				OP_CLEAR: begin
					wipe();
					n_clears++;
				end
				default: begin
					n_ignored++;
				end
			endcase
		endfunction

		task report(string msg);
			$display("MISMATCH at %0t: %s", $time, msg);
			errors++;
		endtask

		task check_response(logic [63:0] value, logic exists);
			rd_t want;
			if (pending_reads.size() == 0) begin
				report($sformatf("response with none pending: value %h exists %b", value, exists));
				return;
			end
			want = pending_reads.pop_front();
			n_checked++;
			if (value !== want.value) begin
				report($sformatf("read_value %h, expected %h", value, want.value));
			end
			if (exists !== want.exists) begin
				report($sformatf("slot_exists %b, expected %b", exists, want.exists));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	int send_idle_pct;
	int rsp_stall_pct;
	int quiet_cycles = 0;
	hist_scoreboard sb;

	lhc_cmd_if cmd_ch ();
	lhc_rsp_if rsp_ch ();

	latency_histogram_counters_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch.sink),
		.rsp    (rsp_ch.source)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(negedge clk) begin
		rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				sb.note_command(cmd_ch.operation, cmd_ch.target_index, cmd_ch.latency_ms,
					cmd_ch.slot);
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				sb.check_response(rsp_ch.read_value, rsp_ch.slot_exists);
			end
			if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Watchdog: no transfer for %0d cycles, %0d reads pending.",
					QUIET_LIMIT, sb.pending_reads.size());
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	task automatic send_cmd(input logic [2:0] op, input logic [4:0] idx,
			input logic [31:0] lat, input logic [3:0] slot);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			@(negedge clk);
			cmd_ch.valid = 1'b0;
		end
		@(negedge clk);
		cmd_ch.valid = 1'b1;
		cmd_ch.operation = op;
		cmd_ch.target_index = idx;
		cmd_ch.latency_ms = lat;
		cmd_ch.slot = slot;
		do @(posedge clk); while (!cmd_ch.ready);
	endtask

	function automatic logic [31:0] pick_latency(logic [4:0] idx);
		int cat;
		int sel;
		logic [31:0] lat;
		cat = idx % NUM_CATEGORIES_DEF;
		sel = $urandom_range(0, 9);
		if (sel < 4) begin
			lat = sb.bound_ms(cat, $urandom_range(0, sb.finite_buckets(cat) - 1));
			lat = lat + $urandom_range(0, 2) - 1;
		end else if (sel < 6) begin
			lat = $urandom_range(0, 200);
		end else if (sel < 8) begin
			lat = $urandom_range(0, 100000);
		end else if (sel == 8) begin
			lat = $urandom;
		end else begin
			lat = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
		end
		return lat;
	endfunction

	task automatic run_random(input int count);
		int pick;
		logic [2:0] op;
		logic [4:0] idx;
		logic [3:0] slot;
		for (int k = 0; k < count; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 42) begin
				op = OP_RECORD;
			end else if (pick < 57) begin
				op = OP_EVENT;
			end else if (pick < 81) begin
				op = OP_READ_HIST;
			end else if (pick < 94) begin
				op = OP_READ_EVENT;
			end else if (pick < 96) begin
				op = OP_CLEAR;
			end else begin
				op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
			end
			if ($urandom_range(0, 9) == 0) begin
				idx = 5'($urandom_range(0, 31));
			end else if (op == OP_EVENT || op == OP_READ_EVENT) begin
				idx = 5'($urandom_range(0, NUM_EVENT_COUNTERS_DEF - 1));
			end else begin
				idx = 5'($urandom_range(0, NUM_CATEGORIES_DEF - 1));
			end
			if ($urandom_range(0, 9) == 0) begin
				slot = 4'($urandom_range(0, 15));
			end else begin
				slot = 4'($urandom_range(0, NUM_SLOTS - 1));
			end
			send_cmd(op, idx, pick_latency(idx), slot);
		end
	endtask

	initial begin
		sb = new;
		clk = 1'b0;
		arst_n = 1'b0;
		send_idle_pct = 19;
		rsp_stall_pct = 19;
		cmd_ch.valid = 1'b0;
		cmd_ch.operation = OP_RECORD;
		cmd_ch.target_index = '0;
		cmd_ch.latency_ms = '0;
		cmd_ch.slot = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_cmd(OP_RECORD, 5'd0, 32'd0, 4'd0);
		send_cmd(OP_RECORD, 5'd0, 32'd2, 4'd0);
		send_cmd(OP_RECORD, 5'd1, 32'd2501, 4'd0);
		send_cmd(OP_RECORD, 5'd2, 32'd10000, 4'd0);
		send_cmd(OP_RECORD, 5'd3, 32'd75000, 4'd0);
		send_cmd(OP_RECORD, 5'd7, 32'hFFFF_FFFF, 4'd15);
		send_cmd(OP_RECORD, 5'd8, 32'd5, 4'd0);
		send_cmd(OP_EVENT, 5'd17, 32'd0, 4'd0);
		send_cmd(OP_EVENT, 5'd18, 32'd0, 4'd0);
		send_cmd(OP_READ_HIST, 5'd0, 32'd0, 4'd0);
		send_cmd(OP_READ_HIST, 5'd1, 32'd0, 4'd5);
		send_cmd(OP_READ_HIST, 5'd3, 32'd0, 4'd5);
		send_cmd(OP_READ_HIST, 5'd7, 32'd0, 4'(SLOT_SUM));
		send_cmd(OP_READ_HIST, 5'd2, 32'd0, 4'(SLOT_COUNT));
		send_cmd(OP_READ_HIST, 5'd8, 32'd0, 4'd0);
		send_cmd(OP_READ_HIST, 5'd0, 32'd0, 4'(NUM_SLOTS));
		send_cmd(OP_READ_EVENT, 5'd17, 32'd0, 4'd15);
		send_cmd(OP_READ_EVENT, 5'd18, 32'd0, 4'd0);
		send_cmd(OP_SPARE_LO, 5'd0, 32'd1, 4'd0);
		send_cmd(OP_SPARE_HI, 5'd31, 32'd1, 4'd0);
		send_cmd(OP_CLEAR, 5'd0, 32'd0, 4'd0);
		send_cmd(OP_READ_HIST, 5'd7, 32'd0, 4'(SLOT_SUM));

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 0;
					rsp_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 70;
					rsp_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					rsp_stall_pct = 70;
				end
				default: begin
					send_idle_pct = 19;
					rsp_stall_pct = 19;
				end
			endcase
			run_random(RANDOM_PER_PHASE);
		end
		@(negedge clk);
		cmd_ch.valid = 1'b0;

		while (sb.pending_reads.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("Covered %0d records, %0d event counts, %0d clears and %0d ignored commands.",
			sb.n_records, sb.n_events, sb.n_clears, sb.n_ignored);
		$display("Checked %0d read responses across no-idle, sender-idle, stall and mixed phases.",
			sb.n_checked);
		if (sb.errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

[files.f]
src/lhc_pkg.sv
src/lhc_if.sv
src/lhc_hist_bank.sv
src/lhc_event_bank.sv
src/latency_histogram_counters_top.sv
tb/latency_histogram_counters_top_tb.sv
